@@ rtl/knnrp_pkg.sv @@
`default_nettype none
package knnrp_pkg;

    // fixed field widths of the channels
    localparam int IN_COORD_W = 21;
    localparam int ID_W       = 24;
    localparam int IN_REFL_W  = 16;
    localparam int OUT_W      = 16;

    // neighbor search and arithmetic constants
    localparam int NEAR_COUNT = 3;
    localparam int Z_SHIFT    = 4;
    localparam int DIGIT_BITS = 4;

    // multiply sequence steps
    localparam logic [2:0] STEP_W01  = 3'd0;
    localparam logic [2:0] STEP_W12  = 3'd1;
    localparam logic [2:0] STEP_W02  = 3'd2;
    localparam logic [2:0] STEP_NUM0 = 3'd3;
    localparam logic [2:0] STEP_NUM1 = 3'd4;
    localparam logic [2:0] STEP_NUM2 = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MSTART,
        S_MWAIT,
        S_SUM,
        S_DSTART,
        S_DWAIT,
        S_COMMIT,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ rtl/knnrp_if.sv @@
`default_nettype none
interface knnrp_in_if;
    import knnrp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  first_point;
    logic [IN_COORD_W-1:0] x_coord;
    logic [IN_COORD_W-1:0] y_coord;
    logic [IN_COORD_W-1:0] z_coord;
    logic [ID_W-1:0]       point_id;
    logic [IN_REFL_W-1:0]  prev_reflectance;

    modport source (output valid, first_point, x_coord, y_coord, z_coord, point_id,
                    prev_reflectance, input ready);
    modport sink (input valid, first_point, x_coord, y_coord, z_coord, point_id,
                  prev_reflectance, output ready);
endinterface

interface knnrp_out_if;
    import knnrp_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] predicted_reflectance;

    modport source (output valid, predicted_reflectance, input ready);
    modport sink (input valid, predicted_reflectance, output ready);
endinterface
`default_nettype wire

@@ rtl/knnrp_ram.sv @@
`default_nettype none
module knnrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/knnrp_mul.sv @@
`default_nettype none
module knnrp_mul #(
    parameter int A_W = 64,
    parameter int B_W = 26
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    output logic                o_done,
    output logic      [A_W-1:0] o_product
);
    import knnrp_pkg::*;

    logic                      r_busy;
    logic [A_W-1:0]            r_a;
    logic [B_W-1:0]            r_b;
    logic [A_W-1:0]            r_acc;
    logic [A_W+DIGIT_BITS-1:0] partial;

    // one radix-16 digit of b per cycle
    assign partial   = r_a * r_b[DIGIT_BITS-1:0];
    assign o_done    = r_busy && (r_b == '0);
    assign o_product = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            r_acc <= r_acc + partial[A_W-1:0];
            r_a   <= r_a << DIGIT_BITS;
            r_b   <= r_b >> DIGIT_BITS;
        end
    end
endmodule
`default_nettype wire

@@ rtl/knnrp_div.sv @@
`default_nettype none
module knnrp_div #(
    parameter int A_W = 64,
    parameter int D_W = 47
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic      [A_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(A_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     trial;
    logic             ge;
    logic [D_W:0]     diff;

    // restoring division, one quotient bit per cycle
    assign trial      = {r_rem, r_q[A_W-1]};
    assign ge         = trial >= {1'b0, r_den};
    assign diff       = trial - {1'b0, r_den};
    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(A_W);
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_q   <= {r_q[A_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ rtl/knn_reflectance_predictor_core.sv @@
// sequence: accept, commit and result for the first two points of a cloud;
// otherwise accept, a scan of the window, up to 6 products, the weight sum when
// three neighbors are kept, a division, commit and result
// throughput: one beat at a time, ready again the cycle after the result beat
// reset: synchronous active low; clears the state, the window count and write slot
`default_nettype none
module knn_reflectance_predictor_core #(
    parameter int WINDOW_DEPTH = 128,
    parameter int COORD_BITS   = 21,
    parameter int REFL_BITS    = 16
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    knnrp_in_if.sink    i_in,
    knnrp_out_if.source o_out
);
    import knnrp_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int DW    = COORD_BITS + 5;
    localparam int PW    = 2 * COORD_BITS + 4;
    localparam int NUM_W = 2 * COORD_BITS + REFL_BITS + 6;
    localparam int DEN_W = 2 * COORD_BITS + 5;
    localparam int BW    = (DW > REFL_BITS) ? DW : REFL_BITS;
    localparam int PAW   = 3 * COORD_BITS;

    t_state r_state, n_state;

    logic [AW-1:0]        r_wslot;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_iss;
    logic [AW-1:0]        r_raddr;
    logic                 r_two;
    logic                 r_v1;
    logic                 r_v2;
    logic [PAW-1:0]       r_pos;
    logic [ID_W-1:0]      r_id;
    logic [DW-1:0]        r_d;
    logic [ID_W-1:0]      r_did;
    logic [REFL_BITS-1:0] r_dref;
    logic [DW-1:0]        r_kd [NEAR_COUNT];
    logic [ID_W-1:0]      r_kid [NEAR_COUNT];
    logic [REFL_BITS-1:0] r_kr [NEAR_COUNT];
    logic [1:0]           r_kept;
    logic [2:0]           r_step;
    logic [PW-1:0]        r_p [NEAR_COUNT];
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [OUT_W-1:0]     r_pred;

    logic                 accept;
    logic [CW-1:0]        n_eff;
    logic [AW-1:0]        back1;
    logic [REFL_BITS-1:0] prev_in;
    logic [PAW-1:0]       pos_rd;
    logic [ID_W-1:0]      id_rd;
    logic [REFL_BITS-1:0] refl_rd;
    logic                 rd_en;
    logic                 pos_we;
    logic                 refl_we;
    logic                 scan_done;
    logic [DW-1:0]        l1_dist;
    logic [1:0]           vmax;
    logic [DW:0]          dsum;
    logic [DEN_W-1:0]     wsum;
    logic [REFL_BITS+1:0] zacc;
    logic [1:0]           zcnt;
    logic                 mul_start;
    logic [NUM_W-1:0]     mul_a;
    logic [BW-1:0]        mul_b;
    logic                 mul_done;
    logic [NUM_W-1:0]     mul_p;
    logic [NUM_W-1:0]     num_acc;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_q;

    assign accept    = (r_state == S_IDLE) && i_in.valid;
    assign n_eff     = i_in.first_point ? '0 : r_count;
    assign back1     = (r_wslot == '0) ? AW'(WINDOW_DEPTH - 1) : r_wslot - 1'b1;
    assign prev_in   = i_in.prev_reflectance[REFL_BITS-1:0];
    assign rd_en     = (r_state == S_SCAN) && (r_iss != '0);
    assign pos_we    = (r_state == S_COMMIT);
    assign refl_we   = accept && !i_in.first_point && (r_count != '0);
    assign scan_done = (r_iss == '0) && !r_v1 && !r_v2;
    assign mul_start = (r_state == S_MSTART);
    assign div_start = (r_state == S_DSTART);
    assign num_acc   = r_num + mul_p;

    assign i_in.ready                  = (r_state == S_IDLE);
    assign o_out.valid                 = (r_state == S_OUT);
    assign o_out.predicted_reflectance = r_pred;

    // window storage
    knnrp_ram #(.WIDTH(PAW), .DEPTH(WINDOW_DEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_wslot),
        .i_wdata (r_pos),
        .i_re    (rd_en),
        .i_raddr (r_raddr),
        .o_rdata (pos_rd)
    );

    knnrp_ram #(.WIDTH(ID_W), .DEPTH(WINDOW_DEPTH)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_wslot),
        .i_wdata (r_id),
        .i_re    (rd_en),
        .i_raddr (r_raddr),
        .o_rdata (id_rd)
    );

    knnrp_ram #(.WIDTH(REFL_BITS), .DEPTH(WINDOW_DEPTH)) u_refl_ram (
        .i_clk   (i_clk),
        .i_we    (refl_we),
        .i_waddr (back1),
        .i_wdata (prev_in),
        .i_re    (rd_en),
        .i_raddr (r_raddr),
        .o_rdata (refl_rd)
    );

    // distance of the entry just read, z weighted for the two-point case
    always_comb begin
        logic [COORD_BITS-1:0] cx, cy, cz, rx, ry, rz, ax, ay, az;
        cx   = r_pos[COORD_BITS-1:0];
        cy   = r_pos[2*COORD_BITS-1:COORD_BITS];
        cz   = r_pos[3*COORD_BITS-1:2*COORD_BITS];
        rx   = pos_rd[COORD_BITS-1:0];
        ry   = pos_rd[2*COORD_BITS-1:COORD_BITS];
        rz   = pos_rd[3*COORD_BITS-1:2*COORD_BITS];
        ax   = (cx > rx) ? cx - rx : rx - cx;
        ay   = (cy > ry) ? cy - ry : ry - cy;
        az   = (cz > rz) ? cz - rz : rz - cz;
        l1_dist = DW'(ax) + DW'(ay) + (r_two ? (DW'(az) << Z_SHIFT) : DW'(az));
    end

    // kept neighbor with the largest (distance, id)
    always_comb begin
        vmax = 2'd0;
        for (int j = 1; j < NEAR_COUNT; j++) begin
            if ((r_kd[j] > r_kd[vmax]) || ((r_kd[j] == r_kd[vmax]) && (r_kid[j] > r_kid[vmax])))
            begin
                vmax = 2'(j);
            end
        end
    end

    // weight sums and the zero-distance fallback
    always_comb begin
        dsum = {1'b0, r_kd[0]} + {1'b0, r_kd[1]};
        wsum = DEN_W'(r_p[0]) + DEN_W'(r_p[1]) + DEN_W'(r_p[2]);
        zacc = '0;
        zcnt = '0;
        for (int j = 0; j < NEAR_COUNT; j++) begin
            if (r_kd[j] == '0) begin
                zacc = zacc + (REFL_BITS+2)'(r_kr[j]);
                zcnt = zcnt + 1'b1;
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_two) begin
            if (r_step == STEP_W01) begin
                mul_a = NUM_W'(r_kd[1]);
                mul_b = BW'(r_kr[0]);
            end else begin
                mul_a = NUM_W'(r_kd[0]);
                mul_b = BW'(r_kr[1]);
            end
        end else begin
            case (r_step)
                STEP_W01: begin
                    mul_a = NUM_W'(r_kd[0]);
                    mul_b = BW'(r_kd[1]);
                end
                STEP_W12: begin
                    mul_a = NUM_W'(r_kd[1]);
                    mul_b = BW'(r_kd[2]);
                end
                STEP_W02: begin
                    mul_a = NUM_W'(r_kd[0]);
                    mul_b = BW'(r_kd[2]);
                end
                STEP_NUM0: begin
                    mul_a = NUM_W'(r_p[1]);
                    mul_b = BW'(r_kr[0]);
                end
                STEP_NUM1: begin
                    mul_a = NUM_W'(r_p[2]);
                    mul_b = BW'(r_kr[1]);
                end
                STEP_NUM2: begin
                    mul_a = NUM_W'(r_p[0]);
                    mul_b = BW'(r_kr[2]);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    knnrp_mul #(.A_W(NUM_W), .B_W(BW)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    knnrp_div #(.A_W(NUM_W), .D_W(DEN_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (r_num),
        .i_den      (r_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (n_eff < CW'(2)) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_two && (dsum == '0)) ? S_DSTART : S_MSTART;
                end
            end
            S_MSTART: n_state = S_MWAIT;
            S_MWAIT: begin
                if (mul_done) begin
                    if (r_two) begin
                        n_state = (r_step == STEP_W01) ? S_MSTART : S_DSTART;
                    end else if (r_step == STEP_W02) begin
                        n_state = S_SUM;
                    end else if (r_step == STEP_NUM2) begin
                        n_state = S_DSTART;
                    end else begin
                        n_state = S_MSTART;
                    end
                end
            end
            S_SUM:    n_state = (wsum != '0) ? S_MSTART : S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_count <= '0;
        end else if (accept && i_in.first_point) begin
            r_wslot <= '0;
            r_count <= '0;
        end else if (r_state == S_COMMIT) begin
            r_wslot <= (r_wslot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
            if (r_count != CW'(WINDOW_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else if (accept) begin
            r_iss <= (n_eff == CW'(2)) ? CW'(2) : ((n_eff < CW'(2)) ? '0 : n_eff);
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (r_iss != '0) begin
                r_iss <= r_iss - 1'b1;
            end
            r_v1 <= (r_iss != '0);
            r_v2 <= r_v1;
        end
    end

    // beat capture, scan pipeline and arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos   <= {i_in.z_coord[COORD_BITS-1:0], i_in.y_coord[COORD_BITS-1:0],
                        i_in.x_coord[COORD_BITS-1:0]};
            r_id    <= i_in.point_id;
            r_two   <= (n_eff == CW'(2));
            r_raddr <= back1;
            r_kept  <= '0;
            r_pred  <= (n_eff == CW'(1)) ? OUT_W'(prev_in) : '0;
        end
        if (r_state == S_SCAN) begin
            if (r_iss != '0) begin
                r_raddr <= (r_raddr == '0) ? AW'(WINDOW_DEPTH - 1) : r_raddr - 1'b1;
            end
            if (r_v1) begin
                r_d    <= l1_dist;
                r_did  <= id_rd;
                r_dref <= refl_rd;
            end
            // first three entries are kept, later ones replace the worst when strictly closer
            if (r_v2) begin
                if (r_kept != 2'(NEAR_COUNT)) begin
                    r_kd[r_kept]  <= r_d;
                    r_kid[r_kept] <= r_did;
                    r_kr[r_kept]  <= r_dref;
                    r_kept        <= r_kept + 1'b1;
                end else if (r_d < r_kd[vmax]) begin
                    r_kd[vmax]  <= r_d;
                    r_kid[vmax] <= r_did;
                    r_kr[vmax]  <= r_dref;
                end
            end
            if (scan_done) begin
                r_step <= STEP_W01;
                if (r_two && (dsum == '0)) begin
                    r_num <= (NUM_W'(r_kr[0]) + NUM_W'(r_kr[1]) + NUM_W'(1)) << 1;
                    r_den <= DEN_W'(4);
                end else begin
                    r_num <= '0;
                    r_den <= DEN_W'(dsum) << 1;
                end
            end
        end
        if ((r_state == S_MWAIT) && mul_done) begin
            r_step <= r_step + 1'b1;
            if (r_two) begin
                if (r_step == STEP_W01) begin
                    r_num <= num_acc;
                end else begin
                    r_num <= (num_acc << 1) + NUM_W'(r_den >> 1);
                end
            end else if (r_step < STEP_NUM0) begin
                r_p[r_step[1:0]] <= mul_p[PW-1:0];
            end else begin
                r_num <= num_acc;
            end
        end
        if (r_state == S_SUM) begin
            if (wsum != '0) begin
                r_num <= '0;
                r_den <= wsum;
            end else begin
                r_num <= NUM_W'(zacc);
                r_den <= DEN_W'(zcnt);
            end
        end
        if ((r_state == S_DWAIT) && div_done) begin
            r_pred <= div_q[OUT_W-1:0];
        end
    end
endmodule
`default_nettype wire

@@ rtl/knnrp_checker.sv @@
`default_nettype none
module knnrp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_data
);
    // a beat is never taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while result pending");

    // an accepted beat closes the input side in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accept");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");
endmodule

bind knn_reflectance_predictor_core knnrp_checker u_knnrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.predicted_reflectance)
);
`default_nettype wire
